[src/sdseq_pkg.sv]
// sdseq_pkg: transaction payload types, register types and fixed codes
// for the sd card init and read sequencer; no dependencies
`default_nettype none

package sdseq_pkg;

   // request functions
   localparam logic [1:0] FUNC_START    = 2'd0;
   localparam logic [1:0] FUNC_COMPLETE = 2'd1;
   localparam logic [1:0] FUNC_READ     = 2'd2;

   // status codes
   localparam logic [2:0] ST_BUSY    = 3'd0;
   localparam logic [2:0] ST_OK      = 3'd1;
   localparam logic [2:0] ST_CMDERR  = 3'd2;
   localparam logic [2:0] ST_PATTERN = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_NOINIT  = 3'd5;

   // card kinds
   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_V1      = 2'd1;
   localparam logic [1:0] KIND_V2_SC   = 2'd2;
   localparam logic [1:0] KIND_SDHC    = 2'd3;

   // sd command indexes
   localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
   localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
   localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
   localparam logic [5:0] CMD_SET_BUS      = 6'd6;
   localparam logic [5:0] CMD_SELECT       = 6'd7;
   localparam logic [5:0] CMD_IF_COND      = 6'd8;
   localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
   localparam logic [5:0] CMD_OP_COND      = 6'd41;
   localparam logic [5:0] CMD_APP          = 6'd55;

   // protocol constants
   localparam logic [7:0]  CHECK_PATTERN  = 8'hAA;
   localparam logic [31:0] OP_COND_ARG_V1 = 32'h00FF_8000;
   localparam logic [31:0] BUS_WIDTH_4    = 32'd2;
   localparam int          BLOCK_SHIFT    = 9;  // 512-byte blocks

   // register indexes and reset values
   localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
   localparam logic [1:0] REG_IF_COND     = 2'd1;
   localparam logic [1:0] REG_OP_COND     = 2'd2;
   localparam logic [9:0]  RETRY_LIMIT_RST = 10'd1000;
   localparam logic [31:0] IF_COND_RST     = 32'h0000_01AA;
   localparam logic [31:0] OP_COND_RST     = 32'h40FF_8000;
   localparam logic [9:0]  RETRY_MAX       = 10'd1023;

   typedef struct packed {
      logic [1:0]  func;
      logic        cmd_failed;
      logic [31:0] response_word;
      logic [31:0] block_address;
   } req_type;

   typedef struct packed {
      logic        issue_valid;
      logic [5:0]  cmd_index;
      logic [31:0] cmd_argument;
      logic        long_response;
      logic        fast_clock;
      logic        wide_bus;
      logic [1:0]  card_kind;
      logic [15:0] card_address;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  powerup_retry_limit;
      logic [31:0] if_cond_argument;
      logic [31:0] op_cond_argument_v2;
   } cfg_type;

endpackage

`default_nettype wire

[src/sdseq_csr.sv]
// sdseq_csr: apb register file holding the sequencer's configuration
// depends on sdseq_pkg
`default_nettype none

module sdseq_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [3:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   output sdseq_pkg::cfg_type       cfg
);
   import sdseq_pkg::*;

   cfg_type cfg_ff;
   logic    wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];
   assign cfg     = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.powerup_retry_limit <= RETRY_LIMIT_RST;
         cfg_ff.if_cond_argument    <= IF_COND_RST;
         cfg_ff.op_cond_argument_v2 <= OP_COND_RST;
      end else if (wr_en) begin
         case (reg_sel)
            REG_RETRY_LIMIT: cfg_ff.powerup_retry_limit <= pwdata[9:0];
            REG_IF_COND:     cfg_ff.if_cond_argument    <= pwdata;
            REG_OP_COND:     cfg_ff.op_cond_argument_v2 <= pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_sel)
         REG_RETRY_LIMIT: prdata = {22'd0, cfg_ff.powerup_retry_limit};
         REG_IF_COND:     prdata = cfg_ff.if_cond_argument;
         REG_OP_COND:     prdata = cfg_ff.op_cond_argument_v2;
         default:         prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

[src/sd_card_init_and_read_sequencer_core.sv]
// sd_card_init_and_read_sequencer_core: host-side sd card command sequencer
// a result is registered on accept, via the skid stage while an earlier one is held
// throughput: one request per cycle; a skid stage behind the result register lets
// one more request in while a result is stalled, then req_stall rises
// reset (synchronous, active high) returns to idle, card unknown, registers to defaults
// depends on sdseq_pkg and sdseq_csr
`default_nettype none

module sd_card_init_and_read_sequencer_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire sdseq_pkg::req_type  req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sdseq_pkg::rsp_type       rsp_data,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [3:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import sdseq_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_CMD0, PH_CMD8, PH_APP41, PH_OP41, PH_CMD2,
      PH_CMD3, PH_CMD7, PH_APP6, PH_BUS6, PH_READY, PH_READ
   } phase_type;

   cfg_type   cfg;

   phase_type phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] rca_ff, rca_in;
   logic [9:0]  retry_ff, retry_in;
   logic        ready_ff, ready_in;
   logic        clk_mode_ff, clk_mode_in;
   logic        bus_mode_ff, bus_mode_in;

   rsp_type   out_ff, skid_ff, result;
   logic      out_v_ff, skid_v_ff;
   logic      accept, pop;

   logic        r_issue;
   logic [5:0]  r_index;
   logic [31:0] r_arg;
   logic [2:0]  r_status;
   logic [10:0] cnt_wide;
   logic [9:0]  cnt_sat;
   logic [2:0]  quiet;

   sdseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall = skid_v_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign pop       = out_v_ff && !rsp_stall;

   // saturating attempt count for acmd41
   assign cnt_wide = {1'b0, retry_ff} + 11'd1;
   assign cnt_sat  = cnt_wide[10] ? RETRY_MAX : cnt_wide[9:0];

   // status when nothing happens
   always_comb begin
      case (phase_ff)
         PH_READY: quiet = ST_OK;
         PH_IDLE:  quiet = ready_ff ? ST_OK : ST_NOINIT;
         default:  quiet = ST_BUSY;
      endcase
   end

   // next state and result for one request
   always_comb begin
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      rca_in      = rca_ff;
      retry_in    = retry_ff;
      ready_in    = ready_ff;
      clk_mode_in = clk_mode_ff;
      bus_mode_in = bus_mode_ff;
      r_issue     = 1'b0;
      r_index     = CMD_GO_IDLE;
      r_arg       = 32'd0;
      r_status    = ST_BUSY;
      case (req_data.func)
         FUNC_START: begin
            kind_in     = KIND_UNKNOWN;
            rca_in      = 16'd0;
            retry_in    = 10'd0;
            ready_in    = 1'b0;
            clk_mode_in = 1'b0;
            bus_mode_in = 1'b0;
            r_issue     = 1'b1;
            r_index     = CMD_GO_IDLE;
            phase_in    = PH_CMD0;
         end
         FUNC_COMPLETE: begin
            case (phase_ff)
               PH_CMD0: begin
                  r_issue  = 1'b1;
                  r_index  = CMD_IF_COND;
                  r_arg    = cfg.if_cond_argument;
                  phase_in = PH_CMD8;
               end
               PH_CMD8: begin
                  if (!req_data.cmd_failed &&
                      req_data.response_word[7:0] != CHECK_PATTERN) begin
                     r_status = ST_PATTERN;
                     phase_in = PH_IDLE;
                  end else begin
                     kind_in  = req_data.cmd_failed ? KIND_V1 : KIND_V2_SC;
                     retry_in = 10'd0;
                     r_issue  = 1'b1;
                     r_index  = CMD_APP;
                     phase_in = PH_APP41;
                  end
               end
               PH_APP41: begin
                  if (req_data.cmd_failed) begin
                     r_status = ST_CMDERR;
                     phase_in = PH_IDLE;
                  end else begin
                     r_issue  = 1'b1;
                     r_index  = CMD_OP_COND;
                     r_arg    = (kind_ff == KIND_V1) ? OP_COND_ARG_V1
                                                     : cfg.op_cond_argument_v2;
                     phase_in = PH_OP41;
                  end
               end
               PH_OP41: begin
                  if (req_data.cmd_failed) begin
                     r_status = ST_CMDERR;
                     phase_in = PH_IDLE;
                  end else begin
                     retry_in = cnt_sat;
                     if (req_data.response_word[31]) begin
                        if (kind_ff == KIND_V2_SC && req_data.response_word[30]) begin
                           kind_in = KIND_SDHC;
                        end
                        r_issue  = 1'b1;
                        r_index  = CMD_ALL_SEND_CID;
                        phase_in = PH_CMD2;
                     end else if (cnt_sat >= cfg.powerup_retry_limit) begin
                        r_status = ST_TIMEOUT;
                        phase_in = PH_IDLE;
                     end else begin
                        r_issue  = 1'b1;
                        r_index  = CMD_APP;
                        phase_in = PH_APP41;
                     end
                  end
               end
               PH_CMD2: begin
                  if (req_data.cmd_failed) begin
                     r_status = ST_CMDERR;
                     phase_in = PH_IDLE;
                  end else begin
                     r_issue  = 1'b1;
                     r_index  = CMD_SEND_RCA;
                     phase_in = PH_CMD3;
                  end
               end
               PH_CMD3: begin
                  if (req_data.cmd_failed) begin
                     r_status = ST_CMDERR;
                     phase_in = PH_IDLE;
                  end else begin
                     rca_in   = req_data.response_word[31:16];
                     r_issue  = 1'b1;
                     r_index  = CMD_SELECT;
                     r_arg    = {req_data.response_word[31:16], 16'd0};
                     phase_in = PH_CMD7;
                  end
               end
               PH_CMD7: begin
                  if (req_data.cmd_failed) begin
                     r_status = ST_CMDERR;
                     phase_in = PH_IDLE;
                  end else begin
                     clk_mode_in = 1'b1;
                     r_issue     = 1'b1;
                     r_index     = CMD_APP;
                     r_arg       = {rca_ff, 16'd0};
                     phase_in    = PH_APP6;
                  end
               end
               PH_APP6: begin
                  if (req_data.cmd_failed) begin
                     r_status = ST_CMDERR;
                     phase_in = PH_IDLE;
                  end else begin
                     r_issue  = 1'b1;
                     r_index  = CMD_SET_BUS;
                     r_arg    = BUS_WIDTH_4;
                     phase_in = PH_BUS6;
                  end
               end
               PH_BUS6: begin
                  if (req_data.cmd_failed) begin
                     r_status = ST_CMDERR;
                     phase_in = PH_IDLE;
                  end else begin
                     bus_mode_in = 1'b1;
                     ready_in    = 1'b1;
                     r_status    = ST_OK;
                     phase_in    = PH_READY;
                  end
               end
               PH_READ: begin
                  r_status = req_data.cmd_failed ? ST_CMDERR : ST_OK;
                  phase_in = PH_READY;
               end
               default: r_status = quiet;
            endcase
         end
         FUNC_READ: begin
            if (!ready_ff) begin
               r_status = ST_NOINIT;
            end else if (phase_ff == PH_READY) begin
               r_issue  = 1'b1;
               r_index  = CMD_READ_SINGLE;
               r_arg    = (kind_ff == KIND_SDHC) ? req_data.block_address
                        : {req_data.block_address[31-BLOCK_SHIFT:0], {BLOCK_SHIFT{1'b0}}};
               phase_in = PH_READ;
            end
         end
         default: r_status = quiet;
      endcase
   end

   // result assembly
   always_comb begin
      result.issue_valid   = r_issue;
      result.cmd_index     = r_index;
      result.cmd_argument  = r_arg;
      result.long_response = r_issue && (r_index == CMD_ALL_SEND_CID);
      result.fast_clock    = clk_mode_in;
      result.wide_bus      = bus_mode_in;
      result.card_kind     = kind_in;
      result.card_address  = rca_in;
      result.status        = r_status;
   end

   // sequencer state, result register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         kind_ff     <= KIND_UNKNOWN;
         rca_ff      <= 16'd0;
         retry_ff    <= 10'd0;
         ready_ff    <= 1'b0;
         clk_mode_ff <= 1'b0;
         bus_mode_ff <= 1'b0;
         out_v_ff    <= 1'b0;
         skid_v_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            kind_ff     <= kind_in;
            rca_ff      <= rca_in;
            retry_ff    <= retry_in;
            ready_ff    <= ready_in;
            clk_mode_ff <= clk_mode_in;
            bus_mode_ff <= bus_mode_in;
         end
         if (skid_v_ff) begin
            if (pop) begin
               out_ff    <= skid_ff;
               skid_v_ff <= 1'b0;
            end
         end else if (!out_v_ff || pop) begin
            out_v_ff <= accept;
            if (accept) begin
               out_ff <= result;
            end
         end else if (accept) begin
            skid_ff   <= result;
            skid_v_ff <= 1'b1;
         end
      end
   end

   // skid entry only exists behind a held result
   assert property (@(posedge clock) disable iff (reset) skid_v_ff |-> out_v_ff)
      else $error("skid stage holds a transaction while result register is empty");

   // an issued command always reports busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.issue_valid |-> rsp_data.status == ST_BUSY)
      else $error("issued command with non-busy status");

   // long response only for cid request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.long_response |-> rsp_data.cmd_index == CMD_ALL_SEND_CID)
      else $error("long response flagged for wrong command");

   // bus widening happens only after the fast clock switch
   assert property (@(posedge clock) disable iff (reset) bus_mode_ff |-> clk_mode_ff)
      else $error("wide bus without fast clock");

   // initialized card has wide bus and a known kind
   assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> bus_mode_ff && kind_ff != KIND_UNKNOWN)
      else $error("ready flag set without completed bus setup");

endmodule

`default_nettype wire
